FILE: src/frl_pkg.sv
// Shared types, codes and helper functions for the floppy record ID locator.
package frl_pkg;

  // Action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_FIND   = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_MARK   = 3'd4;

  // Result codes
  localparam logic [2:0] RC_OK          = 3'd0;
  localparam logic [2:0] RC_NOT_FOUND   = 3'd1;
  localparam logic [2:0] RC_PROTECTED   = 3'd2;
  localparam logic [2:0] RC_BAD_TRACK   = 3'd3;
  localparam logic [2:0] RC_FULL        = 3'd4;
  localparam logic [2:0] RC_UNSUPPORTED = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_WRITE_PROTECT = 2'd0;
  localparam logic [1:0] REG_HIGH_DENSITY  = 2'd1;
  localparam logic [1:0] REG_DISK_PRESENT  = 2'd2;

  // Byte-time accounting
  localparam logic [14:0] SUM_INIT   = 15'd32;
  localparam logic [14:0] SUM_MAX    = 15'h7FFF;
  localparam logic [14:0] CAP_DD     = 15'd6250;
  localparam logic [14:0] CAP_HD     = 15'd10416;
  localparam logic [15:0] NOMINAL    = 16'd128;
  localparam logic [15:0] GAP_FM     = 16'd43;
  localparam logic [15:0] GAP_MFM    = 16'd86;
  localparam logic [7:0]  N_MAX_LEN  = 8'd7;
  localparam logic [7:0]  N_MAX_XFER = 8'd3;
  localparam logic [10:0] XFER_BASE  = 11'd128;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] cylinder;
    logic       side;
    logic [7:0] id_cyl;
    logic [7:0] id_head;
    logic [7:0] id_record;
    logic [7:0] id_size_code;
    logic       fm_mode;
    logic       side_check;
    logic       mark_value;
    logic       data_complete;
    logic [7:0] status_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [4:0]  slot_index;
    logic [7:0]  size_code_out;
    logic [10:0] transfer_bytes;
    logic        deleted_out;
    logic [7:0]  status_out;
    logic [5:0]  record_count;
    logic        over_capacity;
  } rsp_t;

  typedef struct packed {
    logic [1:0] index;
    logic       data;
  } cfg_t;

  // One stored sector ID record, 43 bits
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] h;
    logic [7:0] r;
    logic [7:0] n;
    logic       fm;
    logic       del;
    logic       full;
    logic [7:0] status;
  } rec_t;

  // Record length in MFM byte-times, FM counts double
  function automatic logic [15:0] rec_len(input logic [7:0] n, input logic fm);
    logic [15:0] nom;
    nom = NOMINAL << n[2:0];
    if (n > N_MAX_LEN) begin
      return {1'b0, SUM_MAX};
    end
    return fm ? ((nom + GAP_FM) << 1) : (nom + GAP_MFM);
  endfunction

  function automatic logic [10:0] xfer_bytes(input logic [7:0] n, input logic full);
    return (n <= N_MAX_XFER && full) ? (XFER_BASE << n[1:0]) : 11'd0;
  endfunction

endpackage

FILE: src/frl_stream_if.sv
// Valid/ready channel carrying one payload item.
interface frl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/floppy_record_id_locator_core.sv
// Sector ID record table for an emulated floppy: clear, append, find, write, mark.
//
// Channels: cfg_ch writes the write-protect, media-density and disk-present
// registers (always ready, take effect on the next item). req_ch carries one
// action item; rsp_ch returns exactly one result item for it.
// Timing: an item is taken in one cycle, its track state is read from the
// track RAM in the next, and a find, write or mark then scans the track's
// records from the record RAM one per cycle, stopping at the first match.
// Clear, append and refused actions skip the scan.
// The block works on one item at a time; req_ch is ready only while idle.
// Results pass through an output register, so a new item is taken while
// the previous result still waits on rsp_ch. If rsp_ch stalls, the finished
// result of the next item holds internally until the output register frees.
// Reset clears state, config and output registers and the per-track valid
// bits, so every track reads as empty with a byte-time sum of 32; the record
// RAM is not cleared (only entries below the count are used). No clearing pass.
module floppy_record_id_locator_core #(
  parameter int unsigned TRACKS            = 128,
  parameter int unsigned RECORDS_PER_TRACK = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  frl_stream_if.sink    cfg_ch,
  frl_stream_if.sink    req_ch,
  frl_stream_if.source  rsp_ch
);
  localparam int unsigned TW      = $clog2(TRACKS);
  localparam int unsigned SW      = (RECORDS_PER_TRACK > 1) ? $clog2(RECORDS_PER_TRACK) : 1;
  localparam int unsigned CW      = $clog2(RECORDS_PER_TRACK + 1);
  localparam int unsigned REC_AW  = TW + SW;
  localparam int unsigned REC_DEP = TRACKS << SW;
  localparam int unsigned TS_W    = CW + 16;
  localparam int unsigned REC_W   = $bits(frl_pkg::rec_t);
  localparam logic [9:0]  TRK_LIM = 10'(TRACKS);
  localparam logic [CW-1:0] CNT_MAX = CW'(RECORDS_PER_TRACK);

  typedef enum logic [1:0] {ST_IDLE, ST_TRACK, ST_SCAN, ST_DONE} state_e;

  state_e              state_q, state_d;
  logic                wp_q, hd_q, dp_q;
  logic [TRACKS-1:0]   trk_vld_q;
  logic                vld_rd_q;
  logic                out_vld_q;
  frl_pkg::rsp_t       out_q;

  frl_pkg::req_t       req_q;
  logic [TW-1:0]       trk_idx_q;
  logic                trk_ok_q;
  logic [15:0]         len_q;
  frl_pkg::rsp_t       res_q, res_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_slot_q, slot_d;

  logic                req_acc;
  logic [8:0]          trk_num;

  logic                trk_we;
  logic [TS_W-1:0]     trk_wdata, trk_rdata;
  logic [CW-1:0]       trk_cnt, cnt_inc;
  logic [14:0]         trk_sum, sum_sat, cap;
  logic                trk_ovf, ovf_new;
  logic [16:0]         sum_ext;

  logic                rec_we;
  logic [REC_AW-1:0]   rec_waddr, rec_raddr;
  logic [REC_W-1:0]    rec_rdata;
  frl_pkg::rec_t       rec_rd, rec_new, rec_app;
  logic                rec_hit;
  logic [CW-1:0]       slot_nx;

  assign cfg_ch.ready = 1'b1;
  assign req_ch.ready = (state_q == ST_IDLE);
  assign req_acc      = req_ch.valid && req_ch.ready;
  assign trk_num      = {req_ch.payload.cylinder, req_ch.payload.side};

  assign rsp_ch.valid   = out_vld_q;
  assign rsp_ch.payload = out_q;

  // Per-track state: count, byte-time sum, over-capacity flag
  frl_ram #(.WIDTH(TS_W), .DEPTH(TRACKS)) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_idx_q),
    .wdata_i (trk_wdata),
    .raddr_i (trk_num[TW-1:0]),
    .rdata_o (trk_rdata)
  );

  frl_ram #(.WIDTH(REC_W), .DEPTH(REC_DEP)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_new),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // A track never written reads as its reset value
  assign trk_cnt = vld_rd_q ? trk_rdata[TS_W-1 -: CW] : '0;
  assign trk_sum = vld_rd_q ? trk_rdata[15:1] : frl_pkg::SUM_INIT;
  assign trk_ovf = vld_rd_q ? trk_rdata[0] : 1'b0;
  assign cnt_inc = CW'(trk_cnt + 1'b1);

  assign sum_ext = {2'b00, trk_sum} + {1'b0, len_q};
  assign sum_sat = (sum_ext > {2'b00, frl_pkg::SUM_MAX}) ? frl_pkg::SUM_MAX : sum_ext[14:0];
  assign cap     = hd_q ? frl_pkg::CAP_HD : frl_pkg::CAP_DD;
  assign ovf_new = trk_ovf | (sum_sat > cap);

  assign rec_rd  = frl_pkg::rec_t'(rec_rdata);
  assign slot_nx = CW'(rd_slot_q + 1'b1);
  assign rec_raddr = (state_q == ST_TRACK) ? {trk_idx_q, SW'(0)}
                                           : {trk_idx_q, slot_nx[SW-1:0]};
  assign rec_hit = (rec_rd.c == req_q.id_cyl) && (rec_rd.r == req_q.id_record) &&
                   (rec_rd.fm == req_q.fm_mode) &&
                   (!req_q.side_check || (rec_rd.h[0] == req_q.id_head[0]));

  always_comb begin
    rec_app.c      = req_q.id_cyl;
    rec_app.h      = req_q.id_head;
    rec_app.r      = req_q.id_record;
    rec_app.n      = req_q.id_size_code;
    rec_app.fm     = req_q.fm_mode;
    rec_app.del    = req_q.mark_value;
    rec_app.full   = req_q.data_complete;
    rec_app.status = req_q.status_in;
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    slot_d    = rd_slot_q;
    trk_we    = 1'b0;
    trk_wdata = {cnt_inc, sum_sat, ovf_new};
    rec_we    = 1'b0;
    rec_waddr = {trk_idx_q, trk_cnt[SW-1:0]};
    rec_new   = rec_app;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_TRACK;
        end
      end
      ST_TRACK: begin
        res_d               = '0;
        res_d.record_count  = trk_ok_q ? 6'(trk_cnt) : 6'd0;
        res_d.over_capacity = trk_ok_q & trk_ovf;
        cnt_d               = trk_cnt;
        slot_d              = '0;
        state_d             = ST_DONE;
        if (req_q.action > frl_pkg::ACT_MARK) begin
          res_d.result_code = frl_pkg::RC_UNSUPPORTED;
        end else if (req_q.action == frl_pkg::ACT_CLEAR ||
                     req_q.action == frl_pkg::ACT_APPEND) begin
          if (wp_q) begin
            res_d.result_code = frl_pkg::RC_PROTECTED;
          end else if (!trk_ok_q) begin
            res_d.result_code = frl_pkg::RC_BAD_TRACK;
          end else if (req_q.action == frl_pkg::ACT_CLEAR) begin
            trk_we              = 1'b1;
            trk_wdata           = {CW'(0), frl_pkg::SUM_INIT, 1'b0};
            res_d.record_count  = 6'd0;
            res_d.over_capacity = 1'b0;
          end else if (trk_cnt >= CNT_MAX) begin
            res_d.result_code = frl_pkg::RC_FULL;
          end else begin
            rec_we               = 1'b1;
            trk_we               = 1'b1;
            res_d.slot_index     = 5'(trk_cnt);
            res_d.size_code_out  = rec_app.n;
            res_d.transfer_bytes = frl_pkg::xfer_bytes(rec_app.n, rec_app.full);
            res_d.deleted_out    = rec_app.del;
            res_d.status_out     = rec_app.status;
            res_d.record_count   = 6'(cnt_inc);
            res_d.over_capacity  = ovf_new;
          end
        end else if (req_q.action != frl_pkg::ACT_FIND && wp_q) begin
          res_d.result_code = frl_pkg::RC_PROTECTED;
        end else if (!(dp_q && trk_ok_q) || trk_cnt == '0) begin
          res_d.result_code = frl_pkg::RC_NOT_FOUND;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        slot_d    = slot_nx;
        rec_waddr = {trk_idx_q, rd_slot_q[SW-1:0]};
        rec_new   = rec_rd;
        if (rec_hit) begin
          state_d = ST_DONE;
          if (req_q.action == frl_pkg::ACT_WRITE) begin
            if (rec_rd.n <= frl_pkg::N_MAX_XFER && rec_rd.full) begin
              rec_new.status = 8'd0;
              rec_we         = 1'b1;
            end else begin
              res_d.result_code = frl_pkg::RC_UNSUPPORTED;
            end
          end else if (req_q.action == frl_pkg::ACT_MARK) begin
            rec_new.del = req_q.mark_value;
            rec_we      = 1'b1;
          end
          res_d.slot_index     = 5'(rd_slot_q);
          res_d.size_code_out  = rec_new.n;
          res_d.transfer_bytes = frl_pkg::xfer_bytes(rec_new.n, rec_new.full);
          res_d.deleted_out    = rec_new.del;
          res_d.status_out     = rec_new.status;
        end else if (slot_nx >= cnt_q) begin
          state_d           = ST_DONE;
          res_d.result_code = frl_pkg::RC_NOT_FOUND;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_ch.ready) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Control state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= 1'b0;
      hd_q      <= 1'b0;
      dp_q      <= 1'b0;
      trk_vld_q <= '0;
      vld_rd_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.payload.index)
          frl_pkg::REG_WRITE_PROTECT: wp_q <= cfg_ch.payload.data;
          frl_pkg::REG_HIGH_DENSITY:  hd_q <= cfg_ch.payload.data;
          frl_pkg::REG_DISK_PRESENT:  dp_q <= cfg_ch.payload.data;
          default: ;
        endcase
      end
      if (req_acc) begin
        vld_rd_q <= trk_vld_q[trk_num[TW-1:0]];
      end
      if (trk_we) begin
        trk_vld_q[trk_idx_q] <= 1'b1;
      end
      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        out_q     <= res_q;
        out_vld_q <= 1'b1;
      end else if (rsp_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item and working registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q     <= req_ch.payload;
      trk_idx_q <= trk_num[TW-1:0];
      trk_ok_q  <= ({1'b0, trk_num} < TRK_LIM);
      len_q     <= frl_pkg::rec_len(req_ch.payload.id_size_code,
                                    req_ch.payload.fm_mode);
    end
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    rd_slot_q <= slot_d;
  end

  a_rec_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_we |-> (state_q == ST_TRACK || state_q == ST_SCAN))
    else $error("record write outside an item");

  a_trk_we_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_we |-> !wp_q)
    else $error("track state changed while write protected");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_slot_q < cnt_q))
    else $error("scan beyond track record count");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && rsp_ch.ready && state_q != ST_DONE) |=> !out_vld_q)
    else $error("result delivered twice");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |-> (!out_vld_q || rsp_ch.ready))
    else $error("result overwrites an undelivered one");
endmodule

FILE: src/frl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: tb/frl_locator_checker.sv
// Result checker for the record ID locator: tracks the record table and compares each result.
`timescale 1ns / 100ps
module frl_locator_checker #(
  parameter int unsigned TRACKS            = 128,
  parameter int unsigned RECORDS_PER_TRACK = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  frl_pkg::cfg_t cfg_item_i,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  frl_pkg::req_t req_item_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  frl_pkg::rsp_t rsp_item_i,
  output int            mismatch_count_o,
  output int            pending_o
);

  frl_pkg::rec_t sector_ids  [TRACKS*RECORDS_PER_TRACK];
  logic [5:0]    trk_records [TRACKS];
  logic [14:0]   track_sum   [TRACKS];
  logic          track_over  [TRACKS];
  logic          write_protect;
  logic          high_density;
  logic          disk_present;
  frl_pkg::rsp_t expected_results [$];
  int            mismatches;

  function automatic logic transfer_ok(input frl_pkg::rec_t rec);
    return rec.n <= 8'd3 && rec.full;
  endfunction

  function automatic frl_pkg::rsp_t record_report(input frl_pkg::rsp_t base, input int slot,
                                                  input frl_pkg::rec_t rec);
    frl_pkg::rsp_t r;
    r = base;
    r.slot_index     = slot[4:0];
    r.size_code_out  = rec.n;
    r.transfer_bytes = transfer_ok(rec) ? 11'(128 << rec.n) : 11'd0;
    r.deleted_out    = rec.del;
    r.status_out     = rec.status;
    return r;
  endfunction

  // Carry out one action on the tracked table and return the result it must produce.
  function automatic frl_pkg::rsp_t apply_track_action(input frl_pkg::req_t q);
    frl_pkg::rsp_t r;
    frl_pkg::rec_t rec;
    int   trk;
    int   base;
    int   slot;
    int   i;
    int   len;
    int   total;
    bit   in_range;
    bit   hit;
    r        = '0;
    rec      = '0;
    trk      = int'(q.cylinder) * 2 + int'(q.side);
    in_range = trk < int'(TRACKS);
    base     = trk * int'(RECORDS_PER_TRACK);
    if (q.action > frl_pkg::ACT_MARK) begin
      r.result_code = frl_pkg::RC_UNSUPPORTED;
    end else if (q.action == frl_pkg::ACT_CLEAR || q.action == frl_pkg::ACT_APPEND) begin
      if (write_protect) begin
        r.result_code = frl_pkg::RC_PROTECTED;
      end else if (!in_range) begin
        r.result_code = frl_pkg::RC_BAD_TRACK;
      end else if (q.action == frl_pkg::ACT_CLEAR) begin
        trk_records[trk] = '0;
        track_sum[trk]   = frl_pkg::SUM_INIT;
        track_over[trk]  = 1'b0;
      end else if (trk_records[trk] >= RECORDS_PER_TRACK) begin
        r.result_code = frl_pkg::RC_FULL;
      end else begin
        slot       = int'(trk_records[trk]);
        rec.c      = q.id_cyl;
        rec.h      = q.id_head;
        rec.r      = q.id_record;
        rec.n      = q.id_size_code;
        rec.fm     = q.fm_mode;
        rec.del    = q.mark_value;
        rec.full   = q.data_complete;
        rec.status = q.status_in;
        sector_ids[base + slot] = rec;
        trk_records[trk] = 6'(slot + 1);
        // FM records count double; size codes above 7 saturate the sum
        if (q.id_size_code > 8'd7) begin
          len = int'(frl_pkg::SUM_MAX);
        end else begin
          len = 128 << q.id_size_code;
          len = q.fm_mode ? 2 * (43 + len) : 86 + len;
        end
        total = int'(track_sum[trk]) + len;
        if (total > int'(frl_pkg::SUM_MAX)) total = int'(frl_pkg::SUM_MAX);
        track_sum[trk] = 15'(total);
        if (total > (high_density ? int'(frl_pkg::CAP_HD) : int'(frl_pkg::CAP_DD)))
          track_over[trk] = 1'b1;
        r = record_report(r, slot, rec);
      end
    end else if (q.action != frl_pkg::ACT_FIND && write_protect) begin
      r.result_code = frl_pkg::RC_PROTECTED;
    end else begin
      hit  = 1'b0;
      slot = 0;
      if (disk_present && in_range) begin
        for (i = 0; i < int'(trk_records[trk]) && !hit; i++) begin
          rec = sector_ids[base + i];
          if (rec.c == q.id_cyl && rec.r == q.id_record && rec.fm == q.fm_mode &&
              !(q.side_check && rec.h[0] != q.id_head[0])) begin
            hit  = 1'b1;
            slot = i;
          end
        end
      end
      if (!hit) begin
        r.result_code = frl_pkg::RC_NOT_FOUND;
      end else begin
        rec = sector_ids[base + slot];
        if (q.action == frl_pkg::ACT_WRITE) begin
          if (transfer_ok(rec)) rec.status = '0;
          else r.result_code = frl_pkg::RC_UNSUPPORTED;
        end else if (q.action == frl_pkg::ACT_MARK) begin
          rec.del = q.mark_value;
        end
        sector_ids[base + slot] = rec;
        r = record_report(r, slot, rec);
      end
    end
    if (in_range) begin
      r.record_count  = trk_records[trk];
      r.over_capacity = track_over[trk];
    end
    return r;
  endfunction

  function automatic string result_text(input frl_pkg::rsp_t r);
    return $sformatf("code %0d slot %0d n %0d xfer %0d del %0d status %02h count %0d over %0d",
                     r.result_code, r.slot_index, r.size_code_out, r.transfer_bytes,
                     r.deleted_out, r.status_out, r.record_count, r.over_capacity);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frl_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int t = 0; t < int'(TRACKS); t++) begin
        trk_records[t] = '0;
        track_sum[t]   = frl_pkg::SUM_INIT;
        track_over[t]  = 1'b0;
      end
      write_protect = 1'b0;
      high_density  = 1'b0;
      disk_present  = 1'b0;
      expected_results.delete();
      mismatches       = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_item_i.index)
          frl_pkg::REG_WRITE_PROTECT: write_protect = cfg_item_i.data;
          frl_pkg::REG_HIGH_DENSITY:  high_density  = cfg_item_i.data;
          frl_pkg::REG_DISK_PRESENT:  disk_present  = cfg_item_i.data;
          default: ;
        endcase
      end
      // Results come back in order, so check against the oldest item first
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no item outstanding: %s", $realtime,
                     result_text(rsp_item_i));
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_item_i.result_code    !== want.result_code    ||
              rsp_item_i.slot_index     !== want.slot_index     ||
              rsp_item_i.size_code_out  !== want.size_code_out  ||
              rsp_item_i.transfer_bytes !== want.transfer_bytes ||
              rsp_item_i.deleted_out    !== want.deleted_out    ||
              rsp_item_i.status_out     !== want.status_out     ||
              rsp_item_i.record_count   !== want.record_count   ||
              rsp_item_i.over_capacity  !== want.over_capacity) begin
            if (mismatches < 10)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                       result_text(want), result_text(rsp_item_i));
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        expected_results = {expected_results, apply_track_action(req_item_i)};
      pending_o        <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/tb_floppy_record_id_locator_core.sv
// Top of the record ID locator regression: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_floppy_record_id_locator_core;

  localparam int unsigned TRACKS            = 128;
  localparam int unsigned RECORDS_PER_TRACK = 32;
  localparam int          CYCLE_LIMIT       = 400000;
  localparam int          STALL_AFTER_ITEMS = 350;
  localparam int          STALL_CYCLES      = 400;
  localparam logic [2:0]  ACT_UNDEFINED_LO  = 3'd5;
  localparam logic [2:0]  ACT_UNDEFINED_HI  = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   result_failures;
  int   results_pending;
  int   items_accepted;
  int   burst_left;
  int   cycles;

  frl_stream_if #(.T(frl_pkg::cfg_t)) cfg_ch ();
  frl_stream_if #(.T(frl_pkg::req_t)) req_ch ();
  frl_stream_if #(.T(frl_pkg::rsp_t)) rsp_ch ();

  floppy_record_id_locator_core #(
    .TRACKS            (TRACKS),
    .RECORDS_PER_TRACK (RECORDS_PER_TRACK)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  frl_locator_checker #(
    .TRACKS            (TRACKS),
    .RECORDS_PER_TRACK (RECORDS_PER_TRACK)
  ) u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_ch.valid),
    .cfg_ready_i      (cfg_ch.ready),
    .cfg_item_i       (cfg_ch.payload),
    .req_valid_i      (req_ch.valid),
    .req_ready_i      (req_ch.ready),
    .req_item_i       (req_ch.payload),
    .rsp_valid_i      (rsp_ch.valid),
    .rsp_ready_i      (rsp_ch.ready),
    .rsp_item_i       (rsp_ch.payload),
    .mismatch_count_o (result_failures),
    .pending_o        (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic frl_pkg::req_t sector_request(
    input logic [2:0] act, input logic [7:0] cyl, input logic side,
    input logic [7:0] c, input logic [7:0] h, input logic [7:0] r, input logic [7:0] n,
    input logic fm, input logic cmp, input logic mark, input logic full,
    input logic [7:0] status
  );
    return {act, cyl, side, c, h, r, n, fm, cmp, mark, full, status};
  endfunction

  // Mostly a handful of tracks and small ID sets so finds hit and tracks fill up
  function automatic frl_pkg::req_t random_sector_request(input int clear_pct);
    frl_pkg::req_t q;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < clear_pct)  q.action = frl_pkg::ACT_CLEAR;
    else if (pick < 40)    q.action = frl_pkg::ACT_APPEND;
    else if (pick < 64)    q.action = frl_pkg::ACT_FIND;
    else if (pick < 78)    q.action = frl_pkg::ACT_WRITE;
    else if (pick < 95)    q.action = frl_pkg::ACT_MARK;
    else                   q.action = 3'($urandom_range(ACT_UNDEFINED_LO, ACT_UNDEFINED_HI));
    pick = $urandom_range(0, 99);
    if (pick < 85)         q.cylinder = 8'($urandom_range(0, 1));
    else if (pick < 95)    q.cylinder = 8'($urandom_range(0, 63));
    else                   q.cylinder = 8'($urandom_range(0, 255));
    q.side      = 1'($urandom_range(0, 1));
    q.id_cyl    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    q.id_head   = 8'($urandom);
    q.id_record = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70)         q.id_size_code = 8'($urandom_range(0, 3));
    else if (pick < 90)    q.id_size_code = 8'($urandom_range(4, 7));
    else                   q.id_size_code = 8'($urandom);
    q.fm_mode        = 1'($urandom_range(0, 1));
    q.side_check     = 1'($urandom_range(0, 1));
    q.mark_value     = 1'($urandom_range(0, 1));
    q.data_complete  = ($urandom_range(0, 3) != 0);
    q.status_in      = 8'($urandom);
    return q;
  endfunction

  task automatic write_register(input logic [1:0] reg_index, input logic value);
    @(negedge clk_i);
    cfg_ch.valid   = 1'b1;
    cfg_ch.payload = {reg_index, value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Offer one item, opening a new burst after a random gap when the last one ran out
  task automatic offer_request(input frl_pkg::req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        req_ch.valid = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    req_ch.valid   = 1'b1;
    req_ch.payload = item;
    do @(posedge clk_i); while (!req_ch.ready);
    burst_left--;
    items_accepted++;
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic wp, input logic hd, input logic dp);
    write_register(frl_pkg::REG_WRITE_PROTECT, wp);
    write_register(frl_pkg::REG_HIGH_DENSITY, hd);
    write_register(frl_pkg::REG_DISK_PRESENT, dp);
  endtask

  task automatic run_phase(input logic wp, input logic hd, input logic dp,
                           input int clear_pct, input int count);
    configure(wp, hd, dp);
    repeat (count) offer_request(random_sector_request(clear_pct));
    stop_requests();
  endtask

  // Receiver: stall patterns that change every stretch, plus one long hold-off
  initial begin
    int mode;
    int stretch;
    int hold;
    bit held_once;
    mode      = 0;
    stretch   = 0;
    hold      = 0;
    held_once = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_once && items_accepted >= STALL_AFTER_ITEMS) begin
        held_once = 1'b1;
        hold      = STALL_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        rsp_ch.ready = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(16, 96);
        end
        stretch--;
        case (mode)
          0:       rsp_ch.ready = 1'b1;
          1:       rsp_ch.ready = 1'($urandom_range(0, 1));
          default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    items_accepted = 0;
    burst_left     = 0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: build up track 0, then probe matching, protection-free refusals and bad tracks
    configure(1'b0, 1'b0, 1'b1);
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'h00, 1, 0, 0, 0, 0, 1, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 1, 8'h00, 1, 0, 0, 0, 0, 1, 8'hFF));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 1, 8'h01, 2, 3, 1, 0, 1, 1, 8'h40));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 1, 8'hFE, 1, 3, 1, 0, 0, 1, 8'h20));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 2, 8'h00, 3, 4, 0, 0, 0, 1, 8'h10));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 1, 1, 1, 0, 8'hFF));
    // push the byte-time sum into saturation
    offer_request(sector_request(frl_pkg::ACT_APPEND, 0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'hA5, 1, 0, 0, 1, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'h00, 1, 0, 0, 1, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'h00, 1, 0, 1, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'h00, 2, 0, 1, 1, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'hFF, 2, 0, 1, 1, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_WRITE,  0, 0, 1, 8'h00, 1, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_WRITE,  0, 0, 2, 8'h00, 3, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_WRITE,  0, 0, 8'hFF, 8'h00, 8'hFF,
                                 0, 1, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_MARK,   0, 0, 1, 8'h00, 2, 0, 1, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_MARK,   0, 0, 8'hFF, 8'h00, 8'hFF,
                                 0, 1, 0, 1, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   64, 0, 1, 8'h00, 1,
                                 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 1, 1, 1, 1, 8'hFF));
    offer_request(sector_request(frl_pkg::ACT_CLEAR,  200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(ACT_UNDEFINED_LO, 0, 0, 1, 8'h00, 1, 0, 0, 0, 0, 1, 8'h00));
    offer_request(sector_request(ACT_UNDEFINED_HI, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 1, 1, 1, 1, 8'hFF));
    offer_request(sector_request(frl_pkg::ACT_APPEND, 63, 1, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   63, 1, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    offer_request(sector_request(frl_pkg::ACT_FIND,   0, 0, 1, 8'h00, 1, 0, 0, 0, 0, 0, 8'h00));
    stop_requests();

    // Random phases: write protect, media density and disk presence move between extremes
    run_phase(1'b0, 1'b0, 1'b1, 4, 200);
    run_phase(1'b0, 1'b1, 1'b1, 0, 300);
    run_phase(1'b1, 1'b1, 1'b1, 3, 80);
    run_phase(1'b0, 1'b0, 1'b0, 3, 60);
    run_phase(1'b0, 1'b1, 1'b1, 1, 140);
    run_phase(1'b1, 1'b0, 1'b0, 3, 50);
    run_phase(1'b0, 1'b0, 1'b1, 2, 70);

    // Let any stray result surface before the verdict
    repeat (RECORDS_PER_TRACK + 8) @(posedge clk_i);
    if (result_failures == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
